// ===== design/s2x_pkg.sv =====
// shared types and constants of the scale2x upscaler
package s2x_pkg;

    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 152;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int WIDTH_CFG_W  = 11;
    localparam int HEIGHT_CFG_W = 13;
    localparam int COL_OUT_W    = 10;
    localparam int ROW_W        = 12;
    localparam int PIX_OUT_W    = 32;
    localparam int HEIGHT_MAX   = 4096;

    // result queue
    localparam int N_EMIT  = 3;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic                 frame_done;
        logic                 run_last;
        logic [PIX_OUT_W-1:0] bottom_right;
        logic [PIX_OUT_W-1:0] bottom_left;
        logic [PIX_OUT_W-1:0] top_right;
        logic [PIX_OUT_W-1:0] top_left;
        logic [ROW_W-1:0]     src_row;
        logic [COL_OUT_W-1:0] src_col;
    } result_t;

endpackage

// ===== design/s2x_ram.sv =====
// generic single-write, single-read ram with registered read data
module s2x_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old contents when the same entry is written
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/s2x_corner.sv =====
// scale2x corner rules for one source pixel and its four neighbors
module s2x_corner #(
    parameter int PIXEL_BITS = 32
) (
    input  logic [PIXEL_BITS-1:0] p,
    input  logic [PIXEL_BITS-1:0] up,
    input  logic [PIXEL_BITS-1:0] right,
    input  logic [PIXEL_BITS-1:0] left,
    input  logic [PIXEL_BITS-1:0] down,
    output logic [PIXEL_BITS-1:0] top_left,
    output logic [PIXEL_BITS-1:0] top_right,
    output logic [PIXEL_BITS-1:0] bottom_left,
    output logic [PIXEL_BITS-1:0] bottom_right
);

    logic eq_lu;
    logic eq_ld;
    logic eq_ur;
    logic eq_rd;

    assign eq_lu = (left == up);
    assign eq_ld = (left == down);
    assign eq_ur = (up == right);
    assign eq_rd = (right == down);

    assign top_left     = (eq_lu && !eq_ld && !eq_ur) ? up    : p;
    assign top_right    = (eq_ur && !eq_lu && !eq_rd) ? right : p;
    assign bottom_left  = (eq_ld && !eq_rd && !eq_lu) ? left  : p;
    assign bottom_right = (eq_rd && !eq_ur && !eq_ld) ? down  : p;

endmodule

// ===== design/s2x_rq.sv =====
// result queue: takes up to three results per cycle, hands out one
module s2x_rq (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [s2x_pkg::N_EMIT-1:0]           push_valid,
    input  s2x_pkg::result_t [s2x_pkg::N_EMIT-1:0] push_item,
    output logic                                 room,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output s2x_pkg::result_t                     out_item
);

    s2x_pkg::result_t              entry_reg [s2x_pkg::QDEPTH];
    s2x_pkg::result_t              entry_next [s2x_pkg::QDEPTH];
    logic [s2x_pkg::QPTR_W-1:0]    wptr_reg;
    logic [s2x_pkg::QPTR_W-1:0]    wptr_next;
    logic [s2x_pkg::QPTR_W-1:0]    rptr_reg;
    logic [s2x_pkg::QPTR_W-1:0]    rptr_next;
    logic [s2x_pkg::QCNT_W-1:0]    count_reg;
    logic [s2x_pkg::QCNT_W-1:0]    count_next;
    logic [s2x_pkg::QCNT_W-1:0]    push_total;
    logic [s2x_pkg::QPTR_W-1:0]    offset [s2x_pkg::N_EMIT];
    logic                          pop;

    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rptr_reg];
    assign pop       = out_valid && out_ready;
    // room for a full request worth of results
    assign room      = (count_reg <= s2x_pkg::QCNT_W'(s2x_pkg::QDEPTH - s2x_pkg::N_EMIT));

    always_comb
    begin
        push_total = '0;
        for (int i = 0; i < s2x_pkg::N_EMIT; i++)
        begin
            offset[i]  = s2x_pkg::QPTR_W'(push_total);
            push_total = push_total + s2x_pkg::QCNT_W'(push_valid[i]);
        end
    end

    always_comb
    begin
        for (int k = 0; k < s2x_pkg::QDEPTH; k++)
        begin
            entry_next[k] = entry_reg[k];
        end
        for (int i = 0; i < s2x_pkg::N_EMIT; i++)
        begin
            if (push_valid[i])
            begin
                entry_next[s2x_pkg::QPTR_W'(wptr_reg + offset[i])] = push_item[i];
            end
        end
        wptr_next  = s2x_pkg::QPTR_W'(wptr_reg + s2x_pkg::QPTR_W'(push_total));
        rptr_next  = pop ? s2x_pkg::QPTR_W'(rptr_reg + 1'b1) : rptr_reg;
        count_next = s2x_pkg::QCNT_W'(count_reg + push_total - s2x_pkg::QCNT_W'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < s2x_pkg::QDEPTH; k++)
        begin
            entry_reg[k] <= entry_next[k];
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= s2x_pkg::QCNT_W'(s2x_pkg::QDEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid != '0) |-> room)
        else $error("results pushed without room");
`endif

endmodule

// ===== design/scale2x_pixel_upscaler_top.sv =====
// scale2x 2x pixel upscaler: line buffer ram, corner logic and result queue
//
// usage:
//   s_* carries source pixels in raster order, one request per pixel.
//   m_* carries one 2x2 output block per request, tagged with its source
//   column and row; m_tlast marks the last block caused by one input pixel,
//   m_tuser marks the block of the image's final pixel.
//   cfg_* writes image_width (index 0) and image_height (index 1); write
//   them only while no blocks are pending.
// order: the block of pixel (x, y) goes into the result queue when pixel (x, y+1)
//   is taken; in the final row it follows pixel (x+1, y), and the row's
//   last pixel also brings its own block.
// throughput: one pixel per cycle while the queue has room, the line buffer ram is
//   read once and written once per pixel; in the final row up to three blocks come
//   per pixel, so the single output port through the four-entry result queue
//   limits the pixel rate there.
// reset: counts go to zero, width and height to one, the queue empties;
//   the line buffer is not cleared, row zero never uses its contents.
// stall: when m_tready is low the queue holds its blocks and s_tready falls
//   once fewer than three entries are free.
module scale2x_pixel_upscaler_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pixel_in
    input  logic [s2x_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // src_col, src_row, top_left, top_right, bottom_left, bottom_right, zero pad
    output logic [s2x_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast,
    // frame_done
    output logic                               m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [s2x_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [s2x_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EW    = 2 * PIXEL_BITS;
    localparam int PB    = PIXEL_BITS;
    localparam int NE    = s2x_pkg::N_EMIT;
    localparam int RW    = s2x_pkg::ROW_W;

    // configuration
    logic [s2x_pkg::WIDTH_CFG_W-1:0]  width_cfg_reg;
    logic [s2x_pkg::WIDTH_CFG_W-1:0]  width_cfg_next;
    logic [s2x_pkg::HEIGHT_CFG_W-1:0] height_cfg_reg;
    logic [s2x_pkg::HEIGHT_CFG_W-1:0] height_cfg_next;
    logic [COL_W-1:0]                 col_last;
    logic [RW-1:0]                    row_last;

    // position and pixel history
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [RW-1:0]    row_reg;
    logic [RW-1:0]    row_next;
    logic [PB-1:0]    prev_pixel_reg;
    logic [PB-1:0]    last1_reg;
    logic [PB-1:0]    last2_reg;
    logic [EW-1:0]    cur_reg;
    logic [EW-1:0]    cur_next;
    logic [EW-1:0]    row0_reg;
    logic [EW-1:0]    row0_next;
    logic             fwd_reg;
    logic             fwd_next;
    logic [EW-1:0]    fwd_data_reg;

    // line buffer ram: {row above, current row} per column
    logic [COL_W-1:0] raddr;
    logic [EW-1:0]    ram_rdata;
    logic [EW-1:0]    wdata;
    logic [EW-1:0]    nxt;

    logic             accept;
    logic             last_row;
    logic             end_row;
    logic [PB-1:0]    pix;
    logic [PB-1:0]    old_mid;
    logic [PB-1:0]    old_up;
    logic [PB-1:0]    nxt_mid;

    logic [PB-1:0] e_p     [NE];
    logic [PB-1:0] e_up    [NE];
    logic [PB-1:0] e_right [NE];
    logic [PB-1:0] e_left  [NE];
    logic [PB-1:0] e_down  [NE];
    logic [PB-1:0] e_tl    [NE];
    logic [PB-1:0] e_tr    [NE];
    logic [PB-1:0] e_bl    [NE];
    logic [PB-1:0] e_br    [NE];
    logic [COL_W-1:0] e_col [NE];
    logic [RW-1:0]    e_row [NE];

    logic [NE-1:0]                 push_valid;
    logic [NE-1:0]                 push_last;
    s2x_pkg::result_t [NE-1:0]     push_item;
    logic                          room;
    s2x_pkg::result_t              head;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = room;
    assign pix       = s_tdata[PB-1:0];

    // configuration decode
    always_comb
    begin
        width_cfg_next  = width_cfg_reg;
        height_cfg_next = height_cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                s2x_pkg::REG_IMAGE_WIDTH:
                begin
                    width_cfg_next = cfg_data[s2x_pkg::WIDTH_CFG_W-1:0];
                end
                s2x_pkg::REG_IMAGE_HEIGHT:
                begin
                    height_cfg_next = cfg_data;
                end
            endcase
        end
    end

    // effective last column and last row, out of range values clamped
    always_comb
    begin
        if (width_cfg_reg == '0)
        begin
            col_last = '0;
        end
        else if (32'(width_cfg_reg) > 32'(MAX_WIDTH))
        begin
            col_last = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            col_last = COL_W'(32'(width_cfg_reg) - 32'd1);
        end

        if (height_cfg_reg == '0)
        begin
            row_last = '0;
        end
        else if (32'(height_cfg_reg) > 32'(s2x_pkg::HEIGHT_MAX))
        begin
            row_last = RW'(s2x_pkg::HEIGHT_MAX - 1);
        end
        else
        begin
            row_last = RW'(32'(height_cfg_reg) - 32'd1);
        end
    end

    assign last_row = (row_reg >= row_last);
    assign end_row  = (col_reg >= col_last);

    // entry of this column from the register, next column from the ram or its bypass register
    assign nxt     = fwd_reg ? fwd_data_reg : ram_rdata;
    assign old_mid = cur_reg[PB-1:0];
    assign old_up  = cur_reg[EW-1:PB];
    assign nxt_mid = nxt[PB-1:0];
    assign wdata   = {old_mid, pix};

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        cur_next  = cur_reg;
        row0_next = row0_reg;
        if (accept)
        begin
            if (col_reg == '0)
            begin
                row0_next = wdata;
            end
            if (end_row)
            begin
                col_next = '0;
                row_next = last_row ? '0 : RW'(row_reg + 1'b1);
                cur_next = (col_reg == '0) ? wdata : row0_reg;
            end
            else
            begin
                col_next = COL_W'(col_reg + 1'b1);
                cur_next = nxt;
            end
        end
    end

    // the ram always prefetches the column after the next one to be used
    assign raddr    = COL_W'(col_next + COL_W'(1));
    assign fwd_next = accept && (col_reg == raddr);

    // block of the row above
    always_comb
    begin
        e_p[0]     = old_mid;
        e_up[0]    = (row_reg >= RW'(2)) ? old_up : old_mid;
        e_left[0]  = (col_reg != '0) ? prev_pixel_reg : old_mid;
        e_right[0] = end_row ? old_mid : nxt_mid;
        e_down[0]  = pix;
        e_col[0]   = col_reg;
        e_row[0]   = RW'(row_reg - 1'b1);

        // final row: block to the left of this pixel
        e_p[1]     = last1_reg;
        e_up[1]    = (row_reg != '0) ? prev_pixel_reg : last1_reg;
        e_left[1]  = (col_reg > COL_W'(1)) ? last2_reg : last1_reg;
        e_right[1] = pix;
        e_down[1]  = last1_reg;
        e_col[1]   = COL_W'(col_reg - 1'b1);
        e_row[1]   = row_reg;

        // final row: the row's own last pixel
        e_p[2]     = pix;
        e_up[2]    = (row_reg != '0) ? old_mid : pix;
        e_left[2]  = (col_reg != '0) ? last1_reg : pix;
        e_right[2] = pix;
        e_down[2]  = pix;
        e_col[2]   = col_reg;
        e_row[2]   = row_reg;
    end

    always_comb
    begin
        push_valid[0] = accept && (row_reg != '0);
        push_valid[1] = accept && last_row && (col_reg != '0);
        push_valid[2] = accept && last_row && end_row;
        push_last[2]  = push_valid[2];
        push_last[1]  = push_valid[1] && !push_valid[2];
        push_last[0]  = push_valid[0] && !push_valid[1] && !push_valid[2];
    end

    for (genvar i = 0; i < NE; i++)
    begin : g_emit
        s2x_corner #(
            .PIXEL_BITS (PIXEL_BITS)
        ) u_corner (
            .p            (e_p[i]),
            .up           (e_up[i]),
            .right        (e_right[i]),
            .left         (e_left[i]),
            .down         (e_down[i]),
            .top_left     (e_tl[i]),
            .top_right    (e_tr[i]),
            .bottom_left  (e_bl[i]),
            .bottom_right (e_br[i])
        );

        always_comb
        begin
            push_item[i].src_col      = s2x_pkg::COL_OUT_W'(e_col[i]);
            push_item[i].src_row      = e_row[i];
            push_item[i].top_left     = s2x_pkg::PIX_OUT_W'(e_tl[i]);
            push_item[i].top_right    = s2x_pkg::PIX_OUT_W'(e_tr[i]);
            push_item[i].bottom_left  = s2x_pkg::PIX_OUT_W'(e_bl[i]);
            push_item[i].bottom_right = s2x_pkg::PIX_OUT_W'(e_br[i]);
            push_item[i].run_last     = push_last[i];
            push_item[i].frame_done   = (i == NE - 1);
        end
    end

    s2x_ram #(
        .WIDTH  (EW),
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    s2x_rq u_rq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_item   (head)
    );

    assign m_tdata = {2'b00, head.bottom_right, head.bottom_left, head.top_right,
                      head.top_left, head.src_row, head.src_col};
    assign m_tlast = head.run_last;
    assign m_tuser = head.frame_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= s2x_pkg::WIDTH_CFG_W'(1);
            height_cfg_reg <= s2x_pkg::HEIGHT_CFG_W'(1);
            col_reg        <= '0;
            row_reg        <= '0;
            fwd_reg        <= 1'b0;
        end
        else
        begin
            width_cfg_reg  <= width_cfg_next;
            height_cfg_reg <= height_cfg_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            fwd_reg        <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        row0_reg     <= row0_next;
        fwd_data_reg <= wdata;
        if (accept)
        begin
            prev_pixel_reg <= old_mid;
            last2_reg      <= last1_reg;
            last1_reg      <= pix;
        end
    end

`ifndef SYNTHESIS
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("frame end block not marked last");

    a_final_row_out: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_row && (col_reg != '0)) |=> m_tvalid)
        else $error("final row request left no block");

    a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> $past(accept))
        else $error("ram bypass without a write");
`endif

endmodule

// ===== sim/tb_scale2x_pixel_upscaler_top.sv =====
// testbench of the scale2x upscaler: directed table, sized frames and random frames
module tb_scale2x_pixel_upscaler_top;

    import s2x_pkg::*;

    localparam int LINE_DEPTH     = 1024;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 180;

    typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_e;

    typedef struct {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [IN_TDATA_W-1:0] pixel;
        bit                    typed;
        result_t               want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // model of the block
    logic [PIX_OUT_W-1:0]    upper_row  [LINE_DEPTH];
    logic [PIX_OUT_W-1:0]    middle_row [LINE_DEPTH];
    logic [PIX_OUT_W-1:0]    left_px;
    int unsigned             col_pos;
    int unsigned             row_pos;
    logic [WIDTH_CFG_W-1:0]  width_reg;
    logic [HEIGHT_CFG_W-1:0] height_reg;
    result_t                 fresh_blocks [3];
    int                      fresh_count;

    result_t                 pending_blocks [$];
    stim_row_t               plan [$];
    logic [PIX_OUT_W-1:0]    shades [3];
    int                      fail_count = 0;
    bit                      steady = 1'b0;
    bit                      long_hold_req = 1'b0;

    scale2x_pixel_upscaler_top #(
        .MAX_WIDTH  (LINE_DEPTH),
        .PIXEL_BITS (PIX_OUT_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t epx_block(input int unsigned col, input int unsigned row,
                                          input logic [PIX_OUT_W-1:0] p, input logic [PIX_OUT_W-1:0] up,
                                          input logic [PIX_OUT_W-1:0] right,
                                          input logic [PIX_OUT_W-1:0] left,
                                          input logic [PIX_OUT_W-1:0] down, input logic done);
        result_t b;
        b.src_col      = col[COL_OUT_W-1:0];
        b.src_row      = row[ROW_W-1:0];
        b.top_left     = (left == up && left != down && up != right) ? up : p;
        b.top_right    = (up == right && up != left && right != down) ? right : p;
        b.bottom_left  = (down == left && down != right && left != up) ? left : p;
        b.bottom_right = (right == down && right != up && down != left) ? down : p;
        b.run_last     = 1'b0;
        b.frame_done   = done;
        return b;
    endfunction

    // blocks caused by one source pixel, left in fresh_blocks
    task automatic upscale_pixel(input logic [PIX_OUT_W-1:0] px);
        int unsigned w, h, x, r, c;
        logic [PIX_OUT_W-1:0] old_mid, p, up, right, left;
        bit last_row, end_row;
        w = width_reg;
        h = height_reg;
        if (w == 0) w = 1;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        if (h == 0) h = 1;
        if (h > HEIGHT_MAX) h = HEIGHT_MAX;
        x = col_pos;
        r = row_pos;
        last_row = (r >= h - 1);
        end_row  = (x >= w - 1);
        old_mid  = middle_row[x];
        fresh_count = 0;

        // the row above is complete once its down neighbour arrives
        if (r >= 1)
        begin
            p     = old_mid;
            up    = (r > 1) ? upper_row[x] : p;
            left  = (x > 0) ? left_px : p;
            right = (x + 1 < w) ? middle_row[x + 1] : p;
            fresh_blocks[fresh_count] = epx_block(x, r - 1, p, up, right, left, px, 1'b0);
            fresh_count++;
        end

        left_px       = old_mid;
        upper_row[x]  = old_mid;
        middle_row[x] = px;

        if (last_row)
        begin
            if (x > 0)
            begin
                c    = x - 1;
                p    = middle_row[c];
                up   = (r > 0) ? upper_row[c] : p;
                left = (c > 0) ? middle_row[c - 1] : p;
                fresh_blocks[fresh_count] = epx_block(c, r, p, up, px, left, p, 1'b0);
                fresh_count++;
            end
            if (end_row)
            begin
                p    = px;
                up   = (r > 0) ? upper_row[x] : p;
                left = (x > 0) ? middle_row[x - 1] : p;
                fresh_blocks[fresh_count] = epx_block(x, r, p, up, p, left, p, 1'b1);
                fresh_count++;
            end
        end

        if (fresh_count > 0)
            fresh_blocks[fresh_count - 1].run_last = 1'b1;

        if (end_row)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
        end
        else
        begin
            col_pos = x + 1;
        end
    endtask

    function automatic stim_row_t pix_row(input logic [IN_TDATA_W-1:0] px);
        stim_row_t row;
        row = '{kind: ROW_PIXEL, reg_idx: '0, reg_val: '0, pixel: px, typed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic stim_row_t typed_row(input logic [IN_TDATA_W-1:0] px, input result_t want);
        stim_row_t row;
        row = '{kind: ROW_PIXEL, reg_idx: '0, reg_val: '0, pixel: px, typed: 1'b1, want: want};
        return row;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row = '{kind: ROW_REG, reg_idx: idx, reg_val: val, pixel: '0, typed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic logic [PIX_OUT_W-1:0] pick_shade();
        // a small palette makes equal neighbours common
        if ($urandom_range(0, 3) != 0)
            return shades[$urandom_range(0, 2)];
        return $urandom;
    endfunction

    task automatic refresh_shades();
        foreach (shades[i])
            shades[i] = $urandom;
    endtask

    // sender stops and waits until every pending block is out and the block settles
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_blocks.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            width_reg = val[WIDTH_CFG_W-1:0];
        else
            height_reg = val[HEIGHT_CFG_W-1:0];
    endtask

    task automatic send_pixel(input logic [IN_TDATA_W-1:0] px, input bit typed, input result_t want);
        if (!steady && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge clk); while (!s_tready);
        upscale_pixel(px);
        if (typed)
        begin
            pending_blocks.push_back(want);
        end
        else
        begin
            for (int i = 0; i < fresh_count; i++)
                pending_blocks.push_back(fresh_blocks[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [PIX_OUT_W-1:0] want,
                               input logic [PIX_OUT_W-1:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= 200)
                $error("%s: expected %h, got %h", name, want, got);
        end
    endtask

    // receiver: checks every accepted block and stalls in bursts
    initial
    begin
        int unsigned stall_left;
        result_t got;
        result_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser, m_tlast, m_tdata[OUT_TDATA_W-3:0]};
                if (pending_blocks.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 200)
                        $error("block at col %0d row %0d with nothing pending",
                               got.src_col, got.src_row);
                end
                else
                begin
                    want = pending_blocks.pop_front();
                    check_field("src_col", want.src_col, got.src_col);
                    check_field("src_row", want.src_row, got.src_row);
                    check_field("top_left", want.top_left, got.top_left);
                    check_field("top_right", want.top_right, got.top_right);
                    check_field("bottom_left", want.bottom_left, got.bottom_left);
                    check_field("bottom_right", want.bottom_right, got.bottom_right);
                    check_field("run_last", want.run_last, got.run_last);
                    check_field("frame_done", want.frame_done, got.frame_done);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 12);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog: cycles without any accepted request
    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("** scale2x_pixel_upscaler_top: FAILED **");
        $finish;
    end

    initial
    begin
        int unsigned sent, frame_w, frame_h;

        foreach (upper_row[i])
        begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        left_px    = '0;
        col_pos    = 0;
        row_pos    = 0;
        width_reg  = 1;
        height_reg = 1;

        // one-pixel images: every corner is the pixel itself
        plan.push_back(typed_row(32'hFFFF_FFFF,
            '{frame_done: 1'b1, run_last: 1'b1, bottom_right: 32'hFFFF_FFFF,
              bottom_left: 32'hFFFF_FFFF, top_right: 32'hFFFF_FFFF,
              top_left: 32'hFFFF_FFFF, src_row: '0, src_col: '0}));
        plan.push_back(typed_row(32'h0000_0000,
            '{frame_done: 1'b1, run_last: 1'b1, bottom_right: 32'h0000_0000,
              bottom_left: 32'h0000_0000, top_right: 32'h0000_0000,
              top_left: 32'h0000_0000, src_row: '0, src_col: '0}));
        // zero width and height act as one
        plan.push_back(reg_row(REG_IMAGE_WIDTH, 13'd0));
        plan.push_back(reg_row(REG_IMAGE_HEIGHT, 13'd0));
        plan.push_back(typed_row(32'hA5A5_A5A5,
            '{frame_done: 1'b1, run_last: 1'b1, bottom_right: 32'hA5A5_A5A5,
              bottom_left: 32'hA5A5_A5A5, top_right: 32'hA5A5_A5A5,
              top_left: 32'hA5A5_A5A5, src_row: '0, src_col: '0}));
        // 3x3: centre takes up on top left and down on bottom right
        plan.push_back(reg_row(REG_IMAGE_WIDTH, 13'd3));
        plan.push_back(reg_row(REG_IMAGE_HEIGHT, 13'd3));
        plan.push_back(pix_row(32'h1234_5678));
        plan.push_back(pix_row(32'h8000_0000));
        plan.push_back(pix_row(32'h1234_5678));
        plan.push_back(pix_row(32'h8000_0000));
        plan.push_back(pix_row(32'h7FFF_FFFF));
        plan.push_back(pix_row(32'h1234_5678));
        plan.push_back(pix_row(32'h1234_5678));
        plan.push_back(pix_row(32'h1234_5678));
        plan.push_back(pix_row(32'h8000_0000));
        // next frame: centre takes right on top right and left on bottom left
        plan.push_back(pix_row(32'h0F0F_0F0F));
        plan.push_back(pix_row(32'h8000_0000));
        plan.push_back(pix_row(32'hF0F0_F0F0));
        plan.push_back(pix_row(32'h1234_5678));
        plan.push_back(pix_row(32'h7FFF_FFFF));
        plan.push_back(pix_row(32'h8000_0000));
        plan.push_back(pix_row(32'h0000_FFFF));
        plan.push_back(pix_row(32'h1234_5678));
        plan.push_back(pix_row(32'hFFFF_0000));
        // height above range, then cut short mid-frame past the new last row
        plan.push_back(reg_row(REG_IMAGE_WIDTH, 13'd2));
        plan.push_back(reg_row(REG_IMAGE_HEIGHT, 13'd8191));
        plan.push_back(pix_row(32'h0000_0001));
        plan.push_back(pix_row(32'h0000_0002));
        plan.push_back(pix_row(32'h0000_0002));
        plan.push_back(pix_row(32'h0000_0001));
        plan.push_back(reg_row(REG_IMAGE_HEIGHT, 13'd2));
        plan.push_back(pix_row(32'h0000_0001));
        plan.push_back(pix_row(32'h0000_0002));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                send_pixel(plan[i].pixel, plan[i].typed, plan[i].want);
        end

        // widest row, width above range
        write_reg(REG_IMAGE_WIDTH, 13'd2047);
        write_reg(REG_IMAGE_HEIGHT, 13'd1);
        for (int k = 0; k < LINE_DEPTH; k++)
            send_pixel($urandom, 1'b0, '0);

        // tallest image, one column; the receiver holds off for a while in it
        write_reg(REG_IMAGE_WIDTH, 13'd1);
        write_reg(REG_IMAGE_HEIGHT, 13'(HEIGHT_MAX));
        refresh_shades();
        for (int k = 0; k < HEIGHT_MAX; k++)
        begin
            if (k == 50)
                long_hold_req = 1'b1;
            send_pixel(shades[$urandom_range(0, 1)], 1'b0, '0);
        end

        // width lowered mid-row ends the row early
        write_reg(REG_IMAGE_WIDTH, 13'd9);
        write_reg(REG_IMAGE_HEIGHT, 13'd3);
        refresh_shades();
        for (int k = 0; k < 7; k++)
            send_pixel(pick_shade(), 1'b0, '0);
        write_reg(REG_IMAGE_WIDTH, 13'd4);
        for (int k = 0; k < 9; k++)
            send_pixel(pick_shade(), 1'b0, '0);

        // random frames, mostly small
        sent    = 0;
        frame_w = 1;
        frame_h = 1;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent == 0 || $urandom_range(0, 2) != 0)
            begin
                frame_w = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                      : $urandom_range(1, 6);
                frame_h = $urandom_range(1, 5);
                write_reg(REG_IMAGE_WIDTH, 13'(frame_w));
                write_reg(REG_IMAGE_HEIGHT, 13'(frame_h));
            end
            refresh_shades();
            for (int k = 0; k < frame_w * frame_h; k++)
            begin
                send_pixel(pick_shade(), 1'b0, '0);
                sent++;
                if (sent == 60)
                    wait_quiet();
                if (sent == RANDOM_ITEMS - 40)
                    steady = 1'b1;
            end
        end

        wait_quiet();
        if (fail_count == 0)
            $display("** scale2x_pixel_upscaler_top: PASSED **");
        else
            $display("** scale2x_pixel_upscaler_top: FAILED **");
        $finish;
    end

endmodule
